>>> hdl/bop_pkg.sv
package bop_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int ACTION_W  = 4;
   localparam int ID_W      = 8;
   localparam int K_W       = 4;
   localparam int LIM_W     = K_W + 1;
   localparam int CMP_W     = (SLOT_W > K_W) ? SLOT_W + 1 : K_W + 1;
   localparam int STATUS_W  = 3;
   localparam int FOUND_W   = 4;
   localparam int STATE_W   = 3;
   localparam int ACTCNT_W  = 4;
   localparam int VIOL_W    = 32;
   localparam int CNT_W     = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_VALIDATE    = 4'd0,
      ACT_GET_STATE   = 4'd1,
      ACT_FIND_FREE   = 4'd2,
      ACT_SOFT_RESET  = 4'd3,
      ACT_ACTIVATE    = 4'd4,
      ACT_COMMIT      = 4'd5,
      ACT_CLAIM       = 4'd6,
      ACT_CANCEL      = 4'd7,
      ACT_RELEASE     = 4'd8
   } action_type;

   typedef enum logic [STATE_W-1:0] {
      SLOT_INACTIVE = 3'd0,
      SLOT_FREE     = 3'd1,
      SLOT_DMA      = 3'd2,
      SLOT_READY    = 3'd3,
      SLOT_PROC     = 3'd4
   } slot_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_INVARIANT  = 3'd1,
      STAT_NOT_ACTIVE = 3'd2,
      STAT_RANGE      = 3'd3,
      STAT_ILLEGAL    = 3'd4,
      STAT_BAD_K      = 3'd5,
      STAT_ALREADY    = 3'd6,
      STAT_NO_FREE    = 3'd7
   } status_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      slot_type          data;
   } ram_wr_type;

   function automatic logic k_valid(input logic [K_W-1:0] k);
      return (k == K_W'(1)) || (k == K_W'(2)) || (k == K_W'(4)) || (k == K_W'(8));
   endfunction

   // state of a slot right after activation with k processing buffers
   function automatic slot_type default_slot(input logic [SLOT_W-1:0] idx,
                                             input logic [K_W-1:0] k);
      slot_type s;
      if (CMP_W'(idx) < CMP_W'(2)) begin
         s = SLOT_DMA;
      end else if (CMP_W'(idx) < CMP_W'(k) + CMP_W'(2)) begin
         s = SLOT_FREE;
      end else begin
         s = SLOT_INACTIVE;
      end
      return s;
   endfunction

endpackage

>>> hdl/bop_req_if.sv
interface bop_req_if import bop_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ID_W-1:0]     buffer_id;
   logic [ID_W-1:0]     swap_id;

   modport source(output valid, action, buffer_id, swap_id, input ready);
   modport sink(input valid, action, buffer_id, swap_id, output ready);
endinterface

>>> hdl/bop_rsp_if.sv
interface bop_rsp_if import bop_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FOUND_W-1:0]  found_id;
   logic [STATE_W-1:0]  buffer_state;
   logic                is_active;
   logic [ACTCNT_W-1:0] pool_size;
   logic [VIOL_W-1:0]   violations;
   logic [CNT_W-1:0]    free_slots;
   logic [CNT_W-1:0]    dma_slots;
   logic [CNT_W-1:0]    ready_slots;
   logic [CNT_W-1:0]    busy_slots;
   logic [CNT_W-1:0]    idle_slots;

   modport source(output valid, status, found_id, buffer_state, is_active, pool_size,
                  violations, free_slots, dma_slots, ready_slots, busy_slots,
                  idle_slots, input ready);
   modport sink(input valid, status, found_id, buffer_state, is_active, pool_size,
                violations, free_slots, dma_slots, ready_slots, busy_slots,
                idle_slots, output ready);
endinterface

>>> hdl/bop_csr_if.sv
interface bop_csr_if import bop_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [K_W-1:0] requested_k;

   modport source(output valid, requested_k, input ready);
   modport sink(input valid, requested_k, output ready);
endinterface

>>> hdl/bop_slot_ram.sv
module bop_slot_ram import bop_pkg::*; (
   input  logic       clock,
   input  ram_rd_type rd,
   input  ram_wr_type wr,
   output slot_type   rd_data
);

   slot_type slot_mem [MAX_SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= slot_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/dma_buffer_ownership_pool.sv
// Channel  Direction  Transfer carries
// -------  ---------  -----------------------------------------------------
// req      in         action, buffer_id, swap_id
// rsp      out        status, found_id, buffer_state, is_active, counts
// csr      in         requested_k (always ready)
//
// One command at a time; a transfer on req is checked in EXEC, then get_state,
// claim, cancel and release read their slot (the last three also write it),
// commit reads both slots and writes both, find_free scans (one slot RAM read
// per cycle) and activate sweeps (one RAM write per slot). Reset: synchronous; slot RAM is not cleared, it is
// rewritten by activate and ignored while inactive. A stalled rsp holds its
// result; the next req transfer is still taken and waits only at the end.
module dma_buffer_ownership_pool import bop_pkg::*; (
   input logic      clock,
   input logic      reset,
   bop_req_if.sink  req_chan,
   bop_rsp_if.source rsp_chan,
   bop_csr_if.sink  csr_chan
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_RD_A, S_RD_B, S_WR2, S_SCAN, S_SWEEP, S_RESP
   } fsm_type;

   fsm_type             state_ff;
   logic [ACTION_W-1:0] action_ff;
   logic [ID_W-1:0]     id_ff;
   logic [ID_W-1:0]     rid_ff;
   logic [K_W-1:0]      req_k_ff;
   logic                active_ff;
   logic [K_W-1:0]      k_ff;
   logic [VIOL_W-1:0]   viol_ff;
   logic [CNT_W-1:0]    free_cnt_ff, dma_cnt_ff, ready_cnt_ff, proc_cnt_ff, inact_cnt_ff;
   logic [SLOT_W-1:0]   scan_ff;
   logic [SLOT_W-1:0]   sweep_ff;
   status_type          status_ff;
   logic [FOUND_W-1:0]  found_ff;
   slot_type            bstate_ff;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [FOUND_W-1:0]  rsp_found_ff;
   slot_type            rsp_bstate_ff;
   logic                rsp_active_ff;
   logic [ACTCNT_W-1:0] rsp_actcnt_ff;
   logic [VIOL_W-1:0]   rsp_viol_ff;
   logic [CNT_W-1:0]    rsp_free_ff, rsp_dma_ff, rsp_ready_ff, rsp_proc_ff, rsp_inact_ff;

   ram_rd_type          ram_rd;
   ram_wr_type          ram_wr;
   slot_type            rd_data;

   logic [LIM_W-1:0]    slot_lim;
   logic                id_ok, rid_ok, id_in_pool, rid_in_pool;
   logic                is_move;
   slot_type            move_from, move_to;
   status_type          exec_stat;
   logic                exec_go;
   logic                fin;
   status_type          fin_stat;
   logic                fin_viol;
   logic                scan_last;
   logic                sweep_last;

   bop_slot_ram u_slot_ram (
      .clock   (clock),
      .rd      (ram_rd),
      .wr      (ram_wr),
      .rd_data (rd_data)
   );

   assign slot_lim    = LIM_W'(k_ff) + LIM_W'(2);
   assign id_ok       = id_ff < ID_W'(MAX_SLOTS);
   assign rid_ok      = rid_ff < ID_W'(MAX_SLOTS);
   assign id_in_pool  = id_ff < ID_W'(slot_lim);
   assign rid_in_pool = rid_ff < ID_W'(slot_lim);
   assign scan_last   = (LIM_W'(scan_ff) + LIM_W'(1)) == slot_lim;
   assign sweep_last  = sweep_ff == SLOT_W'(MAX_SLOTS - 1);
   assign is_move     = (action_ff == ACT_CLAIM) || (action_ff == ACT_CANCEL) ||
                        (action_ff == ACT_RELEASE);

   always_comb begin
      move_from = SLOT_READY;
      move_to   = SLOT_FREE;
      if (action_ff == ACT_CLAIM) begin
         move_to = SLOT_PROC;
      end else if (action_ff == ACT_RELEASE) begin
         move_from = SLOT_PROC;
      end
   end

   // checks that need no slot read
   always_comb begin
      exec_stat = STAT_OK;
      exec_go   = 1'b0;
      unique case (action_ff)
         ACT_GET_STATE: begin
            if (!id_ok) begin
               exec_stat = STAT_RANGE;
            end else begin
               exec_go = active_ff;
            end
         end
         ACT_FIND_FREE: begin
            if (!active_ff) begin
               exec_stat = STAT_NOT_ACTIVE;
            end else if (free_cnt_ff == '0) begin
               exec_stat = STAT_NO_FREE;
            end else begin
               exec_go = 1'b1;
            end
         end
         ACT_ACTIVATE: begin
            if (!k_valid(req_k_ff)) begin
               exec_stat = STAT_BAD_K;
            end else if (active_ff) begin
               exec_stat = STAT_ALREADY;
            end else begin
               exec_go = 1'b1;
            end
         end
         ACT_COMMIT: begin
            if (!active_ff) begin
               exec_stat = STAT_NOT_ACTIVE;
            end else if (!id_ok || !rid_ok) begin
               exec_stat = STAT_RANGE;
            end else if (id_ff == rid_ff || !id_in_pool || !rid_in_pool) begin
               exec_stat = STAT_ILLEGAL;
            end else begin
               exec_go = 1'b1;
            end
         end
         ACT_CLAIM, ACT_CANCEL, ACT_RELEASE: begin
            if (!active_ff) begin
               exec_stat = STAT_NOT_ACTIVE;
            end else if (!id_ok) begin
               exec_stat = STAT_RANGE;
            end else if (!id_in_pool) begin
               exec_stat = STAT_ILLEGAL;
            end else begin
               exec_go = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fin      = 1'b0;
      fin_stat = STAT_OK;
      unique case (state_ff)
         S_EXEC: begin
            if (!exec_go) begin
               fin      = 1'b1;
               fin_stat = exec_stat;
            end
         end
         S_RD_A: begin
            if (action_ff == ACT_COMMIT) begin
               if (rd_data != SLOT_DMA) begin
                  fin      = 1'b1;
                  fin_stat = STAT_ILLEGAL;
               end
            end else begin
               fin = 1'b1;
               if (is_move && rd_data != move_from) begin
                  fin_stat = STAT_ILLEGAL;
               end
            end
         end
         S_RD_B: begin
            if (rd_data != SLOT_FREE) begin
               fin      = 1'b1;
               fin_stat = STAT_ILLEGAL;
            end
         end
         S_WR2: begin
            fin = 1'b1;
         end
         S_SCAN: begin
            if (rd_data == SLOT_FREE) begin
               fin = 1'b1;
            end else if (scan_last) begin
               fin      = 1'b1;
               fin_stat = STAT_NO_FREE;
            end
         end
         S_SWEEP: begin
            fin = sweep_last;
         end
         default: begin
         end
      endcase
   end

   assign fin_viol = (fin_stat != STAT_OK) && (fin_stat != STAT_NO_FREE);

   always_comb begin
      ram_rd = '{en: 1'b0, addr: id_ff[SLOT_W-1:0]};
      ram_wr = '{en: 1'b0, addr: id_ff[SLOT_W-1:0], data: SLOT_INACTIVE};
      unique case (state_ff)
         S_EXEC: begin
            ram_rd.en = exec_go;
            if (action_ff == ACT_FIND_FREE) begin
               ram_rd.addr = '0;
            end
         end
         S_RD_A: begin
            if (action_ff == ACT_COMMIT) begin
               ram_rd.en   = rd_data == SLOT_DMA;
               ram_rd.addr = rid_ff[SLOT_W-1:0];
            end else if (is_move) begin
               ram_wr.en   = rd_data == move_from;
               ram_wr.data = move_to;
            end
         end
         S_RD_B: begin
            ram_wr.en   = rd_data == SLOT_FREE;
            ram_wr.data = SLOT_READY;
         end
         S_WR2: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = rid_ff[SLOT_W-1:0];
            ram_wr.data = SLOT_DMA;
         end
         S_SCAN: begin
            ram_rd.en   = 1'b1;
            ram_rd.addr = scan_ff + SLOT_W'(1);
         end
         S_SWEEP: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = sweep_ff;
            ram_wr.data = default_slot(sweep_ff, k_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         req_k_ff     <= K_W'(1);
         active_ff    <= 1'b0;
         k_ff         <= '0;
         viol_ff      <= '0;
         free_cnt_ff  <= '0;
         dma_cnt_ff   <= '0;
         ready_cnt_ff <= '0;
         proc_cnt_ff  <= '0;
         inact_cnt_ff <= CNT_W'(MAX_SLOTS);
      end else begin
         if (csr_chan.valid) begin
            req_k_ff <= csr_chan.requested_k;
         end
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin) begin
            status_ff <= fin_stat;
            state_ff  <= S_RESP;
            if (fin_viol && viol_ff != '1) begin
               viol_ff <= viol_ff + VIOL_W'(1);
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  action_ff <= req_chan.action;
                  id_ff     <= req_chan.buffer_id;
                  rid_ff    <= req_chan.swap_id;
                  found_ff  <= '0;
                  bstate_ff <= SLOT_INACTIVE;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  if (action_ff == ACT_FIND_FREE) begin
                     scan_ff  <= '0;
                     state_ff <= S_SCAN;
                  end else if (action_ff == ACT_ACTIVATE) begin
                     sweep_ff     <= '0;
                     k_ff         <= req_k_ff;
                     active_ff    <= 1'b1;
                     dma_cnt_ff   <= CNT_W'(2);
                     free_cnt_ff  <= CNT_W'(req_k_ff);
                     ready_cnt_ff <= '0;
                     proc_cnt_ff  <= '0;
                     inact_cnt_ff <= CNT_W'(MAX_SLOTS - 2) - CNT_W'(req_k_ff);
                     state_ff     <= S_SWEEP;
                  end else begin
                     state_ff <= S_RD_A;
                  end
               end else if (action_ff == ACT_SOFT_RESET) begin
                  active_ff    <= 1'b0;
                  k_ff         <= '0;
                  viol_ff      <= '0;
                  free_cnt_ff  <= '0;
                  dma_cnt_ff   <= '0;
                  ready_cnt_ff <= '0;
                  proc_cnt_ff  <= '0;
                  inact_cnt_ff <= CNT_W'(MAX_SLOTS);
               end
            end
            S_RD_A: begin
               if (action_ff == ACT_GET_STATE) begin
                  bstate_ff <= rd_data;
               end else if (action_ff == ACT_COMMIT) begin
                  if (!fin) begin
                     state_ff <= S_RD_B;
                  end
               end else if (rd_data == move_from) begin
                  unique case (action_ff)
                     ACT_CLAIM: begin
                        ready_cnt_ff <= ready_cnt_ff - CNT_W'(1);
                        proc_cnt_ff  <= proc_cnt_ff + CNT_W'(1);
                     end
                     ACT_CANCEL: begin
                        ready_cnt_ff <= ready_cnt_ff - CNT_W'(1);
                        free_cnt_ff  <= free_cnt_ff + CNT_W'(1);
                     end
                     default: begin
                        proc_cnt_ff <= proc_cnt_ff - CNT_W'(1);
                        free_cnt_ff <= free_cnt_ff + CNT_W'(1);
                     end
                  endcase
               end
            end
            S_RD_B: begin
               if (!fin) begin
                  free_cnt_ff  <= free_cnt_ff - CNT_W'(1);
                  ready_cnt_ff <= ready_cnt_ff + CNT_W'(1);
                  state_ff     <= S_WR2;
               end
            end
            S_WR2: begin
            end
            S_SCAN: begin
               if (rd_data == SLOT_FREE) begin
                  found_ff <= FOUND_W'(scan_ff);
               end else begin
                  scan_ff <= scan_ff + SLOT_W'(1);
               end
            end
            S_SWEEP: begin
               sweep_ff <= sweep_ff + SLOT_W'(1);
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= found_ff;
                  rsp_bstate_ff <= bstate_ff;
                  rsp_active_ff <= active_ff;
                  rsp_actcnt_ff <= active_ff ? ACTCNT_W'(k_ff + K_W'(2)) : '0;
                  rsp_viol_ff   <= viol_ff;
                  rsp_free_ff   <= free_cnt_ff;
                  rsp_dma_ff    <= dma_cnt_ff;
                  rsp_ready_ff  <= ready_cnt_ff;
                  rsp_proc_ff   <= proc_cnt_ff;
                  rsp_inact_ff  <= inact_cnt_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready = state_ff == S_IDLE;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_id     = rsp_found_ff;
   assign rsp_chan.buffer_state = rsp_bstate_ff;
   assign rsp_chan.is_active    = rsp_active_ff;
   assign rsp_chan.pool_size    = rsp_actcnt_ff;
   assign rsp_chan.violations   = rsp_viol_ff;
   assign rsp_chan.free_slots   = rsp_free_ff;
   assign rsp_chan.dma_slots    = rsp_dma_ff;
   assign rsp_chan.ready_slots  = rsp_ready_ff;
   assign rsp_chan.busy_slots   = rsp_proc_ff;
   assign rsp_chan.idle_slots   = rsp_inact_ff;

endmodule

>>> dv/pool_ownership_checker.sv
module pool_ownership_checker import bop_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bop_req_if          req,
   bop_rsp_if          rsp,
   bop_csr_if          csr,
   output int unsigned mismatch_count,
   output int unsigned owed_count
);

   typedef struct {
      status_type          status;
      logic [FOUND_W-1:0]  found_id;
      logic [STATE_W-1:0]  buffer_state;
      logic                is_active;
      logic [ACTCNT_W-1:0] pool_size;
      logic [VIOL_W-1:0]   violations;
      logic [CNT_W-1:0]    free_slots;
      logic [CNT_W-1:0]    dma_slots;
      logic [CNT_W-1:0]    ready_slots;
      logic [CNT_W-1:0]    busy_slots;
      logic [CNT_W-1:0]    idle_slots;
   } pool_reply_type;

   logic              pool_on;
   logic [K_W-1:0]    pool_k;
   logic [K_W-1:0]    cfg_k;
   logic [VIOL_W-1:0] viol_total;
   slot_type          slots [MAX_SLOTS];
   pool_reply_type    owed_replies [$];

   function automatic bit k_allowed(input logic [K_W-1:0] k);
      case (k)
         K_W'(1), K_W'(2), K_W'(4), K_W'(8): return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void clear_pool();
      pool_on    = 1'b0;
      pool_k     = '0;
      viol_total = '0;
      foreach (slots[i]) slots[i] = SLOT_INACTIVE;
   endfunction

   function automatic status_type reject(input status_type code);
      if (viol_total != '1) viol_total++;
      return code;
   endfunction

   function automatic bit pool_consistent();
      int n_dma;
      int n_other;
      n_dma   = 0;
      n_other = 0;
      if (!pool_on) begin
         if (pool_k != 0) return 1'b0;
         foreach (slots[i]) if (slots[i] != SLOT_INACTIVE) return 1'b0;
         return 1'b1;
      end
      if (!k_allowed(pool_k)) return 1'b0;
      foreach (slots[i]) begin
         if (i >= pool_k + 2) begin
            if (slots[i] != SLOT_INACTIVE) return 1'b0;
         end else if (slots[i] == SLOT_DMA) begin
            n_dma++;
         end else if (slots[i] == SLOT_FREE || slots[i] == SLOT_READY ||
                      slots[i] == SLOT_PROC) begin
            n_other++;
         end else begin
            return 1'b0;
         end
      end
      return n_dma == 2 && n_other == pool_k;
   endfunction

   function automatic status_type check_live();
      if (!pool_consistent()) return reject(STAT_INVARIANT);
      if (!pool_on) return reject(STAT_NOT_ACTIVE);
      return STAT_OK;
   endfunction

   function automatic status_type shift_slot(input logic [ID_W-1:0] id,
                                             input slot_type from, input slot_type to);
      status_type st;
      st = check_live();
      if (st != STAT_OK) return st;
      if (id >= MAX_SLOTS) return reject(STAT_RANGE);
      if (id >= pool_k + 2 || slots[id] != from) return reject(STAT_ILLEGAL);
      slots[id] = to;
      return STAT_OK;
   endfunction

   function automatic pool_reply_type run_pool_command(input logic [ACTION_W-1:0] action,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [ID_W-1:0] rid);
      pool_reply_type r;
      int i;
      r.status       = STAT_OK;
      r.found_id     = '0;
      r.buffer_state = SLOT_INACTIVE;
      r.free_slots   = '0;
      r.dma_slots    = '0;
      r.ready_slots  = '0;
      r.busy_slots   = '0;
      r.idle_slots   = '0;
      case (action)
         ACT_VALIDATE: begin
            if (!pool_consistent()) r.status = reject(STAT_INVARIANT);
         end
         ACT_GET_STATE: begin
            if (id >= MAX_SLOTS) r.status = reject(STAT_RANGE);
            else if (!pool_consistent()) r.status = reject(STAT_INVARIANT);
            else r.buffer_state = slots[id];
         end
         ACT_FIND_FREE: begin
            r.status = check_live();
            if (r.status == STAT_OK) begin
               r.status = STAT_NO_FREE;
               for (i = 0; i < pool_k + 2 && i < MAX_SLOTS; i++) begin
                  if (slots[i] == SLOT_FREE) begin
                     r.found_id = FOUND_W'(i);
                     r.status   = STAT_OK;
                     break;
                  end
               end
            end
         end
         ACT_SOFT_RESET: clear_pool();
         ACT_ACTIVATE: begin
            if (!k_allowed(cfg_k)) r.status = reject(STAT_BAD_K);
            else if (!pool_consistent()) r.status = reject(STAT_INVARIANT);
            else if (pool_on) r.status = reject(STAT_ALREADY);
            else begin
               foreach (slots[j]) begin
                  if (j < 2) slots[j] = SLOT_DMA;
                  else if (j < cfg_k + 2) slots[j] = SLOT_FREE;
                  else slots[j] = SLOT_INACTIVE;
               end
               pool_k  = cfg_k;
               pool_on = 1'b1;
            end
         end
         ACT_COMMIT: begin
            r.status = check_live();
            if (r.status == STAT_OK) begin
               if (id >= MAX_SLOTS || rid >= MAX_SLOTS) begin
                  r.status = reject(STAT_RANGE);
               end else if (id == rid || id >= pool_k + 2 || rid >= pool_k + 2 ||
                            slots[id] != SLOT_DMA || slots[rid] != SLOT_FREE) begin
                  r.status = reject(STAT_ILLEGAL);
               end else begin
                  slots[id]  = SLOT_READY;
                  slots[rid] = SLOT_DMA;
               end
            end
         end
         ACT_CLAIM:   r.status = shift_slot(id, SLOT_READY, SLOT_PROC);
         ACT_CANCEL:  r.status = shift_slot(id, SLOT_READY, SLOT_FREE);
         ACT_RELEASE: r.status = shift_slot(id, SLOT_PROC, SLOT_FREE);
         default: ;
      endcase
      foreach (slots[j]) begin
         case (slots[j])
            SLOT_FREE:     r.free_slots++;
            SLOT_DMA:      r.dma_slots++;
            SLOT_READY:    r.ready_slots++;
            SLOT_PROC:     r.busy_slots++;
            SLOT_INACTIVE: r.idle_slots++;
            default: ;
         endcase
      end
      r.is_active  = pool_on;
      r.pool_size  = pool_on ? ACTCNT_W'(pool_k + 2) : '0;
      r.violations = viol_total;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [VIOL_W-1:0] want,
                                input logic [VIOL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pool_reply_type w;
      if (reset) begin
         clear_pool();
         cfg_k = K_W'(1);
         owed_replies.delete();
         mismatch_count = 0;
      end else begin
         if (csr.valid && csr.ready) cfg_k = csr.requested_k;
         if (rsp.valid && rsp.ready) begin
            if (owed_replies.size() == 0) begin
               $error("rsp transfer with no command outstanding");
               mismatch_count++;
            end else begin
               w = owed_replies.pop_front();
               compare_field("status", w.status, rsp.status);
               compare_field("found_id", w.found_id, rsp.found_id);
               compare_field("buffer_state", w.buffer_state, rsp.buffer_state);
               compare_field("is_active", w.is_active, rsp.is_active);
               compare_field("pool_size", w.pool_size, rsp.pool_size);
               compare_field("violations", w.violations, rsp.violations);
               compare_field("free_slots", w.free_slots, rsp.free_slots);
               compare_field("dma_slots", w.dma_slots, rsp.dma_slots);
               compare_field("ready_slots", w.ready_slots, rsp.ready_slots);
               compare_field("busy_slots", w.busy_slots, rsp.busy_slots);
               compare_field("idle_slots", w.idle_slots, rsp.idle_slots);
            end
         end
         if (req.valid && req.ready)
            owed_replies.push_back(run_pool_command(req.action, req.buffer_id,
                                                    req.swap_id));
      end
      owed_count <= owed_replies.size();
   end

endmodule

>>> dv/tb_top.sv
module tb_top import bop_pkg::*; ();

   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 4'hF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 250;
   localparam int HOLD_PHASE     = 5;
   localparam int DRAIN_PHASE    = 2;
   localparam int N_PHASES       = 9;

   logic clock;
   logic reset;

   bop_req_if req_if();
   bop_rsp_if rsp_if();
   bop_csr_if csr_if();

   int unsigned mismatch_count;
   int unsigned owed_count;

   int          send_idle_pct;
   int          stall_pct;
   int          hold_asked;
   int          quiet_cycles;
   logic [K_W-1:0] cur_k;
   bit          pool_live;
   int          pool_lim;

   int phase_k     [N_PHASES] = '{2, 8, 4, 1, 15, 2, 1, 4, 3};
   int phase_idle  [N_PHASES] = '{0, 56, 0, 13, 0, 0, 0, 13, 56};
   int phase_stall [N_PHASES] = '{0, 0, 56, 13, 0, 0, 56, 13, 0};
   int phase_items [N_PHASES] = '{80, 80, 80, 80, 30, 80, 80, 80, 20};

   dma_buffer_ownership_pool u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   pool_ownership_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr            (csr_if),
      .mismatch_count (mismatch_count),
      .owed_count     (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_cmd(input logic [ACTION_W-1:0] action, input logic [ID_W-1:0] id,
                           input logic [ID_W-1:0] rid);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.action    <= action;
      req_if.buffer_id <= id;
      req_if.swap_id   <= rid;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (action == ACT_SOFT_RESET) begin
         pool_live = 1'b0;
      end else if (action == ACT_ACTIVATE && !pool_live &&
                   (cur_k == 1 || cur_k == 2 || cur_k == 4 || cur_k == 8)) begin
         pool_live = 1'b1;
         pool_lim  = cur_k + 2;
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
   endtask

   task automatic write_k(input logic [K_W-1:0] k);
      csr_if.valid       <= 1'b1;
      csr_if.requested_k <= k;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      cur_k = k;
   endtask

   // ids mostly inside the active window so transitions actually land
   task automatic send_random_cmd();
      int pick;
      int lim;
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] rid;
      pick = $urandom_range(99);
      lim  = pool_live ? pool_lim : 10;
      id   = ID_W'($urandom_range(lim - 1));
      rid  = ID_W'($urandom_range(lim - 1));
      if ($urandom_range(9) == 0) id = ID_W'($urandom_range(255));
      if ($urandom_range(9) == 0) rid = ID_W'($urandom_range(255));
      if (!pool_live && $urandom_range(3) == 0) begin
         action = ACT_ACTIVATE;
      end else if (pick < 4) begin
         action = ACTION_W'($urandom_range(15));
         id     = ID_W'($urandom_range(255));
         rid    = ID_W'($urandom_range(255));
      end else if (pick < 6) begin
         action = ACT_SOFT_RESET;
      end else if (pick < 8) begin
         action = ACT_ACTIVATE;
      end else if (pick < 36) begin
         action = ACT_COMMIT;
      end else if (pick < 54) begin
         action = ACT_CLAIM;
      end else if (pick < 64) begin
         action = ACT_CANCEL;
      end else if (pick < 80) begin
         action = ACT_RELEASE;
      end else if (pick < 88) begin
         action = ACT_FIND_FREE;
      end else if (pick < 95) begin
         action = ACT_GET_STATE;
      end else begin
         action = ACT_VALIDATE;
      end
      send_cmd(action, id, rid);
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_asked) begin
            holds_seen = hold_asked;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_VALIDATE;
      req_if.buffer_id   <= '0;
      req_if.swap_id     <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.requested_k <= '0;
      hold_asked         <= 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      cur_k         = K_W'(1);
      pool_live     = 1'b0;
      pool_lim      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: inactive pool, then k from reset, edge ids and transitions
      send_cmd(ACT_VALIDATE, 0, 0);
      send_cmd(ACT_GET_STATE, 0, 0);
      send_cmd(ACT_GET_STATE, 255, 0);
      send_cmd(ACT_FIND_FREE, 0, 0);
      send_cmd(ACT_CLAIM, 0, 0);
      send_cmd(ACT_COMMIT, 0, 2);
      send_cmd(ACT_ACTIVATE, 0, 0);
      send_cmd(ACT_ACTIVATE, 0, 0);
      send_cmd(ACT_VALIDATE, 0, 0);
      send_cmd(ACT_GET_STATE, 2, 0);
      send_cmd(ACT_FIND_FREE, 0, 0);
      send_cmd(ACT_COMMIT, 1, 1);
      send_cmd(ACT_COMMIT, 16, 2);
      send_cmd(ACT_COMMIT, 0, 255);
      send_cmd(ACT_COMMIT, 3, 2);
      send_cmd(ACT_COMMIT, 0, 2);
      send_cmd(ACT_FIND_FREE, 0, 0);
      send_cmd(ACT_CLAIM, 0, 0);
      send_cmd(ACT_CANCEL, 0, 0);
      send_cmd(ACT_RELEASE, 0, 0);
      send_cmd(ACT_CLAIM, 200, 0);
      send_cmd(ACT_CANCEL, 1, 0);
      send_cmd(ACT_UNKNOWN, 255, 255);
      send_cmd(ACT_SOFT_RESET, 0, 0);
      send_cmd(ACT_GET_STATE, 15, 0);
      wait_drained();
      write_k(0);
      send_cmd(ACT_ACTIVATE, 0, 0);

      for (int p = 0; p < N_PHASES; p++) begin
         wait_drained();
         write_k(K_W'(phase_k[p]));
         send_idle_pct = phase_idle[p];
         stall_pct    <= phase_stall[p];
         send_cmd(ACT_SOFT_RESET, 0, 0);
         send_cmd(ACT_ACTIVATE, 0, 0);
         if (p == HOLD_PHASE) hold_asked <= hold_asked + 1;
         for (int n = 0; n < phase_items[p]; n++) begin
            if (p == DRAIN_PHASE && n == phase_items[p] / 2) wait_drained();
            send_random_cmd();
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
